>>> design/epxf_pkg.sv
// Shared types, constants and the sine table function of the equal-power crossfader.
package epxf_pkg;

    // Field widths fixed by the item formats.
    localparam int SAMPLE_W   = 24;
    localparam int CHAN_W     = 4;
    localparam int MIX_W      = 17;
    localparam int FRAMES_W   = 24;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Mix positions in Q1.16.
    localparam logic [MIX_W-1:0] MIX_ONE   = 17'd65536;
    localparam logic [MIX_W-1:0] MIX_RESET = 17'd32768;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MIX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_FRAMES = 2'd1;

    // Input mode codes.
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_FADE_B = 2'd2;
    localparam logic [1:0] MODE_FADE_A = 2'd3;

    // Queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // pi/2 in Q30.
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    // Operations after classification.
    typedef enum logic [2:0] {
        OP_MIX,
        OP_PASS,
        OP_TICK,
        OP_FADE_B,
        OP_FADE_A
    } t_op;

    // One input item.
    typedef struct packed {
        logic [1:0]                 mode;
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] a_sample;
        logic signed [SAMPLE_W-1:0] b_sample;
        logic                       a_present;
        logic                       b_present;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_sample;
        logic [CHAN_W-1:0]          out_channel;
    } t_out_item;

    // A classified job as it sits in the queue.
    typedef struct packed {
        t_op                        op;
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
    } t_job;

    // A configuration write as seen by the back.
    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Sine in Q1.15 from an angle in Q30, Taylor series to x^15 with truncated terms.
    function automatic logic [WEIGHT_W-1:0] sine_q15(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        logic [63:0] r;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 210;
        sum  = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        r = (64'(sum) + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[WEIGHT_W-1:0];
    endfunction

endpackage

>>> design/equal_power_crossfader_unit.sv
// Top level of the equal-power crossfader: front, job queue and back.
//
//  channel  direction  handshake            payload
//  in       input      i_in_valid/o_in_stall    t_in_item (mode, channel, samples, present)
//  out      output     o_out_valid/i_out_stall  t_out_item (mixed_sample, out_channel)
//  cfg      input      i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// The back handles one job at a time: a two-source mix passes index, read, multiply, sum
// and output states; a single-source pass goes to output; a fade start or a tick that ends or
// idles finishes in idle; other ticks run one multiply and a 17-step restoring divider for the
// ramp. The front holding register and a 4-entry queue let input transfers continue while the
// back works or the output is stalled. Reset is synchronous and active low and returns the mix
// to the center with no fade. The configuration port is always ready.
module equal_power_crossfader_unit #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int FADE_COUNT_WIDTH = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  epxf_pkg::t_in_item                      i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output epxf_pkg::t_out_item                     o_out_data,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [epxf_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [epxf_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import epxf_pkg::*;

    logic    w_push;
    t_job    w_push_job;
    logic    w_q_full;
    logic    w_pop;
    t_job    w_q_head;
    logic    w_q_valid;
    t_cfg_wr w_cfg;

    // Configuration writes complete in the cycle they are offered.
    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    epxf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (w_push),
        .o_push_job (w_push_job),
        .i_q_full   (w_q_full)
    );

    epxf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .o_full     (w_q_full),
        .i_pop      (w_pop),
        .o_head     (w_q_head),
        .o_valid    (w_q_valid)
    );

    epxf_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FADE_COUNT_WIDTH (FADE_COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_q_head),
        .o_pop       (w_pop),
        .i_cfg       (w_cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> design/epxf_front.sv
// Front of the crossfader: takes input transfers, classifies them and feeds the queue.
module epxf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  epxf_pkg::t_in_item i_in_data,
    output logic              o_push,
    output epxf_pkg::t_job    o_push_job,
    input  logic              i_q_full
);
    import epxf_pkg::*;

    logic r_valid;
    t_job r_job;
    t_job n_job;
    logic n_keep;
    logic w_accept;

    // The holding register drains into the queue whenever the queue has room.
    assign o_push     = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push_job = r_job;

    // Classify the item; a sample pair with no source present is dropped here.
    always_comb begin
        n_job.channel = i_in_data.channel;
        n_job.a       = i_in_data.a_sample;
        n_job.b       = i_in_data.b_sample;
        n_job.op      = OP_TICK;
        n_keep        = 1'b1;
        unique case (i_in_data.mode)
            MODE_SAMPLE: begin
                if (i_in_data.a_present && i_in_data.b_present) begin
                    n_job.op = OP_MIX;
                end else begin
                    n_job.op = OP_PASS;
                    n_job.a  = i_in_data.a_present ? i_in_data.a_sample
                                                   : i_in_data.b_sample;
                end
                n_keep = i_in_data.a_present || i_in_data.b_present;
            end
            MODE_TICK:   n_job.op = OP_TICK;
            MODE_FADE_B: n_job.op = OP_FADE_B;
            MODE_FADE_A: n_job.op = OP_FADE_A;
            default:     n_job.op = OP_TICK;
        endcase
    end

    // Holding register between the input port and the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_valid <= n_keep;
                r_job   <= n_job;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

>>> design/epxf_queue.sv
// Short job queue that decouples the front from the back.
module epxf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  epxf_pkg::t_job i_push_job,
    output logic           o_full,
    input  logic           i_pop,
    output epxf_pkg::t_job o_head,
    output logic           o_valid
);
    import epxf_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QDEPTH))
        else $error("queue fill count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue pushed while full");
`endif

endmodule

>>> design/epxf_back.sv
// Back of the crossfader: fade state, equal-power mixing and the output register.
module epxf_back #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int FADE_COUNT_WIDTH = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  epxf_pkg::t_job      i_q_head,
    output logic                o_pop,
    input  epxf_pkg::t_cfg_wr   i_cfg,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output epxf_pkg::t_out_item o_out_data
);
    import epxf_pkg::*;

    localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IPROD_W  = MIX_W + IDX_W + 1;
    localparam int CMP_W    = (FADE_COUNT_WIDTH > FRAMES_W) ? FADE_COUNT_WIDTH : FRAMES_W;
    localparam int FPROD_W  = FADE_COUNT_WIDTH + MIX_W;
    localparam int REM_W    = FRAMES_W + 1;
    localparam int PROD_W   = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACC_W    = PROD_W + 1;
    localparam int DCNT_W   = $clog2(MIX_W);
    localparam logic [FADE_COUNT_WIDTH-1:0] CMAX = {FADE_COUNT_WIDTH{1'b1}};
    localparam logic signed [ACC_W-1:0] SAT_MAX = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_IDX,
        S_READ,
        S_MUL,
        S_SUM,
        S_TMUL,
        S_DIV,
        S_UPD,
        S_OUT
    } t_state;

    // Quarter-sine table, evaluated at elaboration.
    logic [WEIGHT_W-1:0] c_sine [SINE_TABLE_DEPTH + 1];
    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
        localparam logic [63:0] XK = (Q30_HALF_PI * 64'(k)) / SINE_TABLE_DEPTH;
        assign c_sine[k] = sine_q15(XK);
    end

    t_state                      r_state;
    logic [MIX_W-1:0]            r_mix;
    logic [MIX_W-1:0]            r_start;
    logic                        r_toward_b;
    logic                        r_active;
    logic [FADE_COUNT_WIDTH-1:0] r_elapsed;
    logic [FRAMES_W-1:0]         r_frames;
    logic [MIX_W-1:0]            r_dist;
    logic [CHAN_W-1:0]           r_chan;
    logic signed [SAMPLE_W-1:0]  r_a;
    logic signed [SAMPLE_W-1:0]  r_b;
    logic [IDX_W-1:0]            r_idx;
    logic [WEIGHT_W-1:0]         r_wa;
    logic [WEIGHT_W-1:0]         r_wb;
    logic signed [PROD_W-1:0]    r_pa;
    logic signed [PROD_W-1:0]    r_pb;
    logic signed [SAMPLE_W-1:0]  r_res;
    logic [REM_W-1:0]            r_rem;
    logic [MIX_W-1:0]            r_low;
    logic [MIX_W-1:0]            r_q;
    logic [DCNT_W-1:0]           r_cnt;
    logic                        r_out_valid;
    t_out_item                   r_out;

    logic [IPROD_W-1:0]          n_iprod;
    logic [IDX_W+1:0]            n_idx_wide;
    logic [IDX_W-1:0]            n_idx;
    logic [FADE_COUNT_WIDTH-1:0] n_elapsed;
    logic                        n_done;
    logic [MIX_W-1:0]            n_dist;
    logic [FPROD_W-1:0]          n_fprod;
    logic [REM_W-1:0]            n_trial;
    logic                        n_ge;
    logic [REM_W-1:0]            n_rem;
    logic signed [ACC_W-1:0]     n_acc;
    logic signed [ACC_W-1:0]     n_shift;
    logic signed [SAMPLE_W-1:0]  n_sat;
    logic [MIX_W-1:0]            n_cfg_mix;
    logic                        w_out_free;

    assign o_pop       = (r_state == S_IDLE) && i_q_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Table index from the mix position, rounded and held within the table.
    always_comb begin
        n_iprod    = IPROD_W'(r_mix) * IPROD_W'(SINE_TABLE_DEPTH) + IPROD_W'(32768);
        n_idx_wide = n_iprod[IPROD_W-1:16];
        if (n_idx_wide > (IDX_W+2)'(SINE_TABLE_DEPTH)) begin
            n_idx = IDX_W'(SINE_TABLE_DEPTH);
        end else begin
            n_idx = n_idx_wide[IDX_W-1:0];
        end
    end

    // Tick bookkeeping: saturating elapsed count, end test and distance to travel.
    always_comb begin
        n_elapsed = (r_elapsed != CMAX) ? r_elapsed + 1'b1 : r_elapsed;
        n_done    = (CMP_W'(n_elapsed) >= CMP_W'(r_frames)) || (n_elapsed == CMAX);
        n_dist    = r_toward_b ? (MIX_ONE - r_start) : r_start;
        n_fprod   = FPROD_W'(r_elapsed) * FPROD_W'(r_dist);
    end

    // One restoring division step per cycle; the quotient stays below 2^17.
    always_comb begin
        n_trial = {r_rem[REM_W-2:0], r_low[MIX_W-1]};
        n_ge    = (n_trial >= {1'b0, r_frames});
        n_rem   = n_ge ? (n_trial - {1'b0, r_frames}) : n_trial;
    end

    // Weighted sum, rounded to nearest in Q0 with ties upward, then saturated.
    always_comb begin
        n_acc   = ACC_W'(r_pa) + ACC_W'(r_pb) + ACC_W'(16384);
        n_shift = n_acc >>> 15;
        if (n_shift > SAT_MAX) begin
            n_sat = SAT_MAX[SAMPLE_W-1:0];
        end else if (n_shift < SAT_MIN) begin
            n_sat = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            n_sat = n_shift[SAMPLE_W-1:0];
        end
    end

    // Manual mix writes are clamped to full B.
    assign n_cfg_mix = (i_cfg.data[MIX_W-1:0] > MIX_ONE) ? MIX_ONE : i_cfg.data[MIX_W-1:0];

    // Sequencer, fade state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mix       <= MIX_RESET;
            r_start     <= '0;
            r_toward_b  <= 1'b0;
            r_active    <= 1'b0;
            r_elapsed   <= '0;
            r_frames    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register empties on a transfer unless a new result replaces it.
            if (!i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_chan <= i_q_head.channel;
                        r_a    <= i_q_head.a;
                        r_b    <= i_q_head.b;
                        unique case (i_q_head.op)
                            OP_MIX: begin
                                r_state <= S_IDX;
                            end
                            OP_PASS: begin
                                r_res   <= i_q_head.a;
                                r_state <= S_OUT;
                            end
                            OP_FADE_B, OP_FADE_A: begin
                                r_start    <= r_mix;
                                r_toward_b <= (i_q_head.op == OP_FADE_B);
                                r_elapsed  <= '0;
                                r_active   <= 1'b1;
                            end
                            OP_TICK: begin
                                if (r_active) begin
                                    r_elapsed <= n_elapsed;
                                    r_dist    <= n_dist;
                                    if (n_done) begin
                                        r_mix    <= r_toward_b ? MIX_ONE : '0;
                                        r_active <= 1'b0;
                                    end else begin
                                        r_state <= S_TMUL;
                                    end
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_IDX: begin
                    r_idx   <= n_idx;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_wb    <= c_sine[r_idx];
                    r_wa    <= c_sine[IDX_W'(SINE_TABLE_DEPTH) - r_idx];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_pa    <= r_a * $signed({1'b0, r_wa});
                    r_pb    <= r_b * $signed({1'b0, r_wb});
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_res   <= n_sat;
                    r_state <= S_OUT;
                end
                S_TMUL: begin
                    r_rem   <= REM_W'(n_fprod >> MIX_W);
                    r_low   <= n_fprod[MIX_W-1:0];
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_low <= {r_low[MIX_W-2:0], 1'b0};
                    r_q   <= {r_q[MIX_W-2:0], n_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DCNT_W'(MIX_W - 1)) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_mix   <= r_toward_b ? (r_start + r_q) : (r_start - r_q);
                    r_state <= S_IDLE;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid        <= 1'b1;
                        r_out.mixed_sample <= r_res;
                        r_out.out_channel  <= r_chan;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // The user must offer configuration writes only while the block is idle; the block does not enforce it.
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_MANUAL_MIX: begin
                        r_mix    <= n_cfg_mix;
                        r_active <= 1'b0;
                    end
                    CFG_FADE_FRAMES: begin
                        r_frames <= i_cfg.data[FRAMES_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    a_mix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mix <= MIX_ONE)
        else $error("mix position beyond full scale");
    a_cfg_cancels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && (i_cfg.index == CFG_MANUAL_MIX)) |=> !r_active)
        else $error("manual mix write left a fade running");
    a_div_in_fade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_active && (r_rem < {1'b0, r_frames})))
        else $error("ramp division out of step");
`endif

endmodule
